### hw/rtl/ieee_float_arith_rtz_macros.svh
// Assertion macros used by the checker file.
`ifndef IEEE_FLOAT_ARITH_RTZ_MACROS_SVH
`define IEEE_FLOAT_ARITH_RTZ_MACROS_SVH

// Implication checked every clock outside reset.
`define IFA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Expression that holds at every clock outside reset.
`define IFA_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`endif

### hw/rtl/ifa_pkg.sv
// Shared constants and controller/datapath interface types.
package ifa_pkg;

    localparam int NW = 57;
    localparam int EW = 12;
    localparam int SW = 24;
    localparam int CW = 5;

    localparam logic [31:0] HALF_QNAN   = 32'd32256;
    localparam logic [31:0] HALF_INF    = 32'd31744;
    localparam logic [31:0] SINGLE_QNAN = 32'd2143289344;
    localparam logic [31:0] SINGLE_INF  = 32'd2139095040;

    localparam logic [1:0] KIND_ADD = 2'd0;
    localparam logic [1:0] KIND_SUB = 2'd1;
    localparam logic [1:0] KIND_MUL = 2'd2;
    localparam logic [1:0] KIND_DIV = 2'd3;

    localparam logic [CW-1:0] DIV_STEPS_HALF   = CW'(13);
    localparam logic [CW-1:0] DIV_STEPS_SINGLE = CW'(26);

    typedef struct packed {
        logic load;
        logic align;
        logic mul;
        logic dnorm;
        logic div_init;
        logic div_step;
        logic norm;
        logic pack;
    } t_cmd;

    typedef struct packed {
        logic       special;
        logic [1:0] kind;
        logic       sig_norm;
        logic       n_done;
        logic       out_free;
    } t_status;

endpackage

### hw/rtl/ieee_float_arith_rtz.sv
// Round-toward-zero binary16/binary32 add, subtract, multiply and divide unit.
//
// Input channel: i_in_valid/o_in_ready carry i_kind (0 add, 1 sub, 2 mul,
// 3 div) and raw operands i_operand_a, i_operand_b. Output channel
// o_out_valid/i_out_ready carries o_result_bits in the selected format.
// Register 0 at byte address 0 of the APB port: bit 0 selects binary32
// (1) or binary16 (0); it resets to binary16.
// One operation is in flight at a time; the next one is taken once the
// sequencer returns to idle, even while the last result is still waiting.
// Steps per operation, from acceptance to result valid:
//   special operands: load, then pack
//   add/sub: load, align, normalize steps, pack
//   mul: load, multiply, normalize steps, pack
//   div: load, prenormalize shifts, 13 (binary16) or 26 (binary32) divider
//        steps, normalize steps, pack.
// The divider retires one quotient bit per cycle; the normalizer shifts
// eight bits or one bit per cycle.
// Reset is synchronous and clears the sequencer and output valid.
// A stalled receiver holds the result register; the sequencer waits in its
// pack step until the register frees.
module ieee_float_arith_rtz (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_operand_a,
    input  logic [31:0] i_operand_b,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_result_bits,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ifa_pkg::*;

    logic    r_fmt;
    t_cmd    cmd;
    t_status status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= 1'b0;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_fmt <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'b0 : {31'b0, r_fmt};

    ifa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fmt      (r_fmt),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ifa_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fmt         (r_fmt),
        .i_kind        (i_kind),
        .i_operand_a   (i_operand_a),
        .i_operand_b   (i_operand_b),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_result_bits (o_result_bits)
    );

endmodule

### hw/rtl/ifa_ctrl.sv
// Sequencer for unpack, align, multiply, divide, normalize and pack steps.
module ifa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fmt,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  ifa_pkg::t_status i_status,
    output ifa_pkg::t_cmd    o_cmd
);
    import ifa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_ALIGN, S_MUL, S_DNORM, S_DIV, S_NORM, S_PACK
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) n_state = S_LOAD;
            end
            S_LOAD: begin
                if (i_status.special) begin
                    n_state = S_PACK;
                end else begin
                    case (i_status.kind) inside
                        KIND_ADD, KIND_SUB: n_state = S_ALIGN;
                        KIND_MUL:           n_state = S_MUL;
                        default:            n_state = S_DNORM;
                    endcase
                end
            end
            S_ALIGN: begin
                o_cmd.align = 1'b1;
                n_state = S_NORM;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_NORM;
            end
            S_DNORM: begin
                o_cmd.dnorm = 1'b1;
                if (i_status.sig_norm) begin
                    o_cmd.div_init = 1'b1;
                    n_cnt = i_fmt ? DIV_STEPS_SINGLE : DIV_STEPS_HALF;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) n_state = S_NORM;
            end
            S_NORM: begin
                o_cmd.norm = 1'b1;
                if (i_status.n_done) n_state = S_PACK;
            end
            S_PACK: begin
                // hold until the output register is free
                if (i_status.out_free) begin
                    o_cmd.pack = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

### hw/rtl/ifa_dpath.sv
// Datapath: operand unpack, add alignment, multiplier, restoring divider, normalizer, pack.
module ifa_dpath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fmt,
    input  logic [1:0]       i_kind,
    input  logic [31:0]      i_operand_a,
    input  logic [31:0]      i_operand_b,
    input  ifa_pkg::t_cmd    i_cmd,
    output ifa_pkg::t_status o_status,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [31:0]      o_result_bits
);
    import ifa_pkg::*;

    typedef struct packed {
        logic                 sign;
        logic [SW-1:0]        sig;
        logic signed [EW-1:0] lsb;
        logic                 nan;
        logic                 inf;
        logic                 zero;
    } t_unp;

    function automatic t_unp f_unpack(input logic fmt, input logic [31:0] x);
        logic [7:0]  be;
        logic [22:0] fr;
        logic [7:0]  emask;
        t_unp        u;
        if (fmt) begin
            be = x[30:23]; fr = x[22:0]; emask = 8'hFF; u.sign = x[31];
        end else begin
            be = {3'b0, x[14:10]}; fr = {13'b0, x[9:0]}; emask = 8'h1F; u.sign = x[15];
        end
        u.nan  = (be == emask) && (fr != '0);
        u.inf  = (be == emask) && (fr == '0);
        u.zero = (be == '0) && (fr == '0);
        u.sig  = fmt ? {(be != '0), fr} : {13'b0, (be != '0), fr[9:0]};
        u.lsb  = ((be == '0) ? 12'sd1 : $signed({4'b0, be}))
                 - (fmt ? 12'sd150 : 12'sd25);
        return u;
    endfunction

    function automatic logic [31:0] f_zero(input logic fmt, input logic s);
        return fmt ? {s, 31'b0} : {16'b0, s, 15'b0};
    endfunction

    logic                 r_sa, r_sb, r_sign, r_special, r_out_valid;
    logic [1:0]           r_kind;
    logic [SW-1:0]        r_siga, r_sigb;
    logic signed [EW-1:0] r_lsba, r_lsbb, r_e;
    logic [NW-1:0]        r_n;
    logic [SW+1:0]        r_rem;
    logic [31:0]          r_spec_val, r_result;

    // unpack and special cases
    t_unp        ua, ub, ta, tb;
    logic        spec;
    logic [31:0] spec_val, qnan_c, inf_c;
    logic        psign;

    always_comb begin
        ua = f_unpack(i_fmt, i_operand_a);
        ub = f_unpack(i_fmt, i_operand_b);
        if (i_kind == KIND_SUB) ub.sign = ~ub.sign;
        qnan_c = i_fmt ? SINGLE_QNAN : HALF_QNAN;
        inf_c  = i_fmt ? SINGLE_INF : HALF_INF;
        psign  = ua.sign ^ ub.sign;
        spec     = 1'b1;
        spec_val = qnan_c;
        ta = ua;
        tb = ub;
        if (ua.nan || ub.nan) begin
            spec_val = qnan_c;
        end else begin
            case (i_kind)
                KIND_ADD, KIND_SUB: begin
                    if (ua.inf) begin
                        spec_val = (ub.inf && ua.sign != ub.sign) ? qnan_c
                                   : (f_zero(i_fmt, ua.sign) | inf_c);
                    end else if (ub.inf) begin
                        spec_val = f_zero(i_fmt, ub.sign) | inf_c;
                    end else if (ua.zero && ub.zero) begin
                        spec_val = f_zero(i_fmt, ua.sign & ub.sign);
                    end else begin
                        spec = 1'b0;
                        // larger magnitude goes first
                        if (ua.lsb < ub.lsb || (ua.lsb == ub.lsb && ua.sig < ub.sig)) begin
                            ta = ub;
                            tb = ua;
                        end
                    end
                end
                KIND_MUL: begin
                    if ((ua.inf && ub.zero) || (ua.zero && ub.inf)) spec_val = qnan_c;
                    else if (ua.inf || ub.inf) spec_val = f_zero(i_fmt, psign) | inf_c;
                    else if (ua.zero || ub.zero) spec_val = f_zero(i_fmt, psign);
                    else spec = 1'b0;
                end
                default: begin
                    if ((ua.zero && ub.zero) || (ua.inf && ub.inf)) spec_val = qnan_c;
                    else if (ua.inf || ub.zero) spec_val = f_zero(i_fmt, psign) | inf_c;
                    else if (ub.inf || ua.zero) spec_val = f_zero(i_fmt, psign);
                    else spec = 1'b0;
                end
            endcase
        end
    end

    // add alignment with sticky
    logic signed [EW-1:0] d;
    logic [NW-1:0]        ax, afull, ay, asum;
    logic                 ast, effsub;

    always_comb begin
        d     = r_lsba - r_lsbb;
        ax    = {1'b0, r_siga, 32'b0};
        afull = {1'b0, r_sigb, 32'b0};
        if (d >= 12'sd57) begin
            ay  = '0;
            ast = (afull != '0);
        end else begin
            ay  = afull >> d[5:0];
            ast = ((ay << d[5:0]) != afull);
        end
        effsub = (r_sa != r_sb);
        asum   = effsub ? (ax - ay - NW'(ast)) : (ax + ay);
    end

    // multiplier and divider step
    logic [2*SW-1:0] prod;
    logic            dcmp;
    logic [SW+1:0]   ddiff;
    logic            a_nrm, b_nrm;

    always_comb begin
        prod  = r_siga * r_sigb;
        dcmp  = (r_rem >= {2'b0, r_sigb});
        ddiff = dcmp ? (r_rem - {2'b0, r_sigb}) : r_rem;
        a_nrm = i_fmt ? r_siga[23] : r_siga[10];
        b_nrm = i_fmt ? r_sigb[23] : r_sigb[10];
    end

    // pack with truncation
    logic signed [EW-1:0] mb, emin, target, sft, biased;
    logic [NW-1:0]        psig;
    logic                 sub_norm;
    logic [31:0]          pres;

    always_comb begin
        mb     = i_fmt ? 12'sd23 : 12'sd10;
        emin   = i_fmt ? -12'sd149 : -12'sd24;
        target = 12'sd56 - mb + r_e;
        if (target < emin) target = emin;
        sft  = target - r_e;
        psig = (sft >= 12'sd57) ? '0 : (r_n >> sft[5:0]);
        sub_norm = i_fmt ? !psig[23] : !psig[10];
        biased   = sub_norm ? 12'sd0 : (target - emin + 12'sd1);
        if (r_special) begin
            pres = r_spec_val;
        end else if (r_n == '0 || psig == '0) begin
            pres = f_zero(i_fmt, r_sign);
        end else if (i_fmt) begin
            pres = (biased >= 12'sd255) ? {r_sign, 31'h7F7FFFFF}
                   : {r_sign, biased[7:0], psig[22:0]};
        end else begin
            pres = (biased >= 12'sd31) ? {16'b0, r_sign, 15'h7BFF}
                   : {16'b0, r_sign, biased[4:0], psig[9:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sa       <= ta.sign;
            r_sb       <= tb.sign;
            r_siga     <= ta.sig;
            r_sigb     <= tb.sig;
            r_lsba     <= ta.lsb;
            r_lsbb     <= tb.lsb;
            r_special  <= spec;
            r_spec_val <= spec_val;
            r_kind     <= i_kind;
        end
        if (i_cmd.align) begin
            r_n    <= asum;
            r_e    <= r_lsba - 12'sd32;
            r_sign <= (effsub && asum == '0) ? 1'b0 : r_sa;
        end
        if (i_cmd.mul) begin
            r_n    <= {9'b0, prod};
            r_e    <= r_lsba + r_lsbb;
            r_sign <= r_sa ^ r_sb;
        end
        if (i_cmd.dnorm) begin
            if (!a_nrm) begin
                r_siga <= {r_siga[SW-2:0], 1'b0};
                r_lsba <= r_lsba - 12'sd1;
            end
            if (!b_nrm) begin
                r_sigb <= {r_sigb[SW-2:0], 1'b0};
                r_lsbb <= r_lsbb - 12'sd1;
            end
        end
        if (i_cmd.div_init) begin
            r_rem  <= {2'b0, r_siga};
            r_n    <= '0;
            r_e    <= r_lsba - r_lsbb - (i_fmt ? 12'sd25 : 12'sd12);
            r_sign <= r_sa ^ r_sb;
        end
        if (i_cmd.div_step) begin
            r_rem <= {ddiff[SW:0], 1'b0};
            r_n   <= {r_n[NW-2:0], dcmp};
        end
        if (i_cmd.norm && !o_status.n_done) begin
            // coarse step of eight, then single bits
            if (r_n[NW-1:NW-8] == '0) begin
                r_n <= {r_n[NW-9:0], 8'b0};
                r_e <= r_e - 12'sd8;
            end else begin
                r_n <= {r_n[NW-2:0], 1'b0};
                r_e <= r_e - 12'sd1;
            end
        end
        if (i_cmd.pack) r_result <= pres;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.pack) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.special  = r_special;
    assign o_status.kind     = r_kind;
    assign o_status.sig_norm = a_nrm && b_nrm;
    assign o_status.n_done   = r_n[NW-1] || (r_n == '0);
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_result_bits     = r_result;

endmodule

### hw/rtl/ifa_checker.sv
// Port-level checks for the float unit, bound to the top level.
`include "ieee_float_arith_rtz_macros.svh"

module ifa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_result_bits,
    input logic [31:0] prdata
);
    `IFA_ASSERT_IMP(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    `IFA_ASSERT_IMP(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_result_bits))
    `IFA_ASSERT_IMP(a_one_in_flight, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `IFA_ASSERT_ALWAYS(a_prdata_upper, i_clk, i_rst_n, prdata[31:1] == 31'b0)
endmodule

bind ieee_float_arith_rtz ifa_checker u_ifa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_result_bits (o_result_bits),
    .prdata        (prdata)
);

### dv/ieee_float_arith_rtz_tb.sv
// Testbench for the round-toward-zero binary16/binary32 arithmetic unit.
`timescale 1ns / 1ps

module ieee_float_arith_rtz_tb;
    import ifa_pkg::*;

    localparam int          LIMIT_CYCLES = 800000;
    localparam int          SETTLE       = 120;
    localparam logic [2:0]  REG_FORMAT   = 3'd0;

    typedef struct {
        bit              sign;
        longint unsigned sig;
        int              lsb;
        bit              nan;
        bit              inf;
        bit              zero;
    } fp_parts_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_kind = KIND_ADD;
    logic [31:0] i_operand_a = '0;
    logic [31:0] i_operand_b = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [31:0] o_result_bits;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    bit [31:0]   expected_results[$];
    bit          fmt_single = 1'b0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_off_cycles = 0;
    int          error_count = 0;
    int          cycle_count = 0;

    ieee_float_arith_rtz u_top (.*);

    always #10 i_clk = ~i_clk;

    // ---------------- predictor ----------------
    function automatic int mant_bits(bit fs);
        return fs ? 23 : 10;
    endfunction

    function automatic int exp_bits(bit fs);
        return fs ? 8 : 5;
    endfunction

    function automatic bit [31:0] quiet_nan(bit fs);
        return fs ? SINGLE_QNAN : HALF_QNAN;
    endfunction

    function automatic bit [31:0] inf_bits(bit fs);
        return fs ? SINGLE_INF : HALF_INF;
    endfunction

    function automatic bit [31:0] zero_bits(bit fs, bit s);
        return 32'(s) << (mant_bits(fs) + exp_bits(fs));
    endfunction

    function automatic fp_parts_t split(bit fs, bit [31:0] x);
        fp_parts_t   p;
        int          mb = mant_bits(fs);
        int          eb = exp_bits(fs);
        bit [31:0]   emask = (32'd1 << eb) - 1;
        bit [31:0]   be = (x >> mb) & emask;
        bit [31:0]   fr = x & ((32'd1 << mb) - 1);
        p.sign = x[mb + eb];
        p.nan  = (be == emask) && (fr != 0);
        p.inf  = (be == emask) && (fr == 0);
        p.zero = (be == 0) && (fr == 0);
        p.sig  = fr | ((be != 0) ? (64'd1 << mb) : 64'd0);
        p.lsb  = ((be == 0) ? 1 : int'(be)) - (fs ? 127 : 15) - mb;
        return p;
    endfunction

    // Truncate n * 2^e into the selected format.
    function automatic bit [31:0] pack_rtz(bit fs, bit s, longint unsigned n, int e);
        int              mb = mant_bits(fs);
        int              eb = exp_bits(fs);
        int              emin = 1 - (fs ? 127 : 15) - mb;
        int              msb = 63;
        int              target;
        int              sh;
        longint unsigned sg;
        int unsigned     biased;
        if (n == 0) return zero_bits(fs, s);
        while (n[msb] == 1'b0) msb--;
        target = msb - mb + e;
        if (target < emin) target = emin;
        sh = target - e;
        if (sh >= 64) sg = 0;
        else if (sh >= 0) sg = n >> sh;
        else if (-sh < 40) sg = n << (-sh);
        else sg = 0;
        if (sg == 0) return zero_bits(fs, s);
        if (sg < (64'd1 << mb)) biased = 0;
        else biased = target - emin + 1;
        if (biased >= (32'd1 << eb) - 1) return zero_bits(fs, s) | (inf_bits(fs) - 1);
        return zero_bits(fs, s) | (biased << mb) | (32'(sg) & ((32'd1 << mb) - 1));
    endfunction

    function automatic bit [31:0] sum_rtz(bit fs, fp_parts_t a, fp_parts_t b);
        fp_parts_t       t;
        longint unsigned x, y, full, n;
        int unsigned     d;
        bit              st;
        if (a.nan || b.nan) return quiet_nan(fs);
        if (a.inf) begin
            if (b.inf && a.sign != b.sign) return quiet_nan(fs);
            return zero_bits(fs, a.sign) | inf_bits(fs);
        end
        if (b.inf) return zero_bits(fs, b.sign) | inf_bits(fs);
        if (a.zero && b.zero) return zero_bits(fs, a.sign & b.sign);
        if (a.zero) return pack_rtz(fs, b.sign, b.sig, b.lsb);
        if (b.zero) return pack_rtz(fs, a.sign, a.sig, a.lsb);
        if (a.lsb < b.lsb || (a.lsb == b.lsb && a.sig < b.sig)) begin
            t = a; a = b; b = t;
        end
        d = a.lsb - b.lsb;
        x = a.sig << 32;
        full = b.sig << 32;
        if (d >= 64) begin
            y = 0;
            st = 1'b1;
        end else begin
            y = full >> d;
            st = (y << d) != full;
        end
        if (a.sign == b.sign) begin
            n = x + y;
        end else begin
            if (x == y && !st) return zero_bits(fs, 1'b0);
            n = x - y - (st ? 64'd1 : 64'd0);
        end
        return pack_rtz(fs, a.sign, n, a.lsb - 32);
    endfunction

    function automatic bit [31:0] product_rtz(bit fs, fp_parts_t a, fp_parts_t b);
        bit s = a.sign ^ b.sign;
        if (a.nan || b.nan) return quiet_nan(fs);
        if ((a.inf && b.zero) || (a.zero && b.inf)) return quiet_nan(fs);
        if (a.inf || b.inf) return zero_bits(fs, s) | inf_bits(fs);
        if (a.zero || b.zero) return zero_bits(fs, s);
        return pack_rtz(fs, s, a.sig * b.sig, a.lsb + b.lsb);
    endfunction

    function automatic bit [31:0] quotient_rtz(bit fs, fp_parts_t a, fp_parts_t b);
        bit s = a.sign ^ b.sign;
        int mb = mant_bits(fs);
        int k = mb + 2;
        if (a.nan || b.nan) return quiet_nan(fs);
        if ((a.zero && b.zero) || (a.inf && b.inf)) return quiet_nan(fs);
        if (a.inf || b.zero) return zero_bits(fs, s) | inf_bits(fs);
        if (b.inf || a.zero) return zero_bits(fs, s);
        // bring subnormals up to a leading one
        while (a.sig < (64'd1 << mb)) begin a.sig <<= 1; a.lsb--; end
        while (b.sig < (64'd1 << mb)) begin b.sig <<= 1; b.lsb--; end
        return pack_rtz(fs, s, (a.sig << k) / b.sig, a.lsb - b.lsb - k);
    endfunction

    function automatic bit [31:0] arith_rtz(bit fs, logic [1:0] op, bit [31:0] ra,
                                            bit [31:0] rb);
        bit [31:0] mask = fs ? 32'hFFFF_FFFF : 32'h0000_FFFF;
        fp_parts_t a = split(fs, ra & mask);
        fp_parts_t b = split(fs, rb & mask);
        bit [31:0] r;
        case (op)
            KIND_ADD: r = sum_rtz(fs, a, b);
            KIND_SUB: begin
                b.sign = ~b.sign;
                r = sum_rtz(fs, a, b);
            end
            KIND_MUL: r = product_rtz(fs, a, b);
            default:  r = quotient_rtz(fs, a, b);
        endcase
        return r & mask;
    endfunction

    // ---------------- drivers ----------------
    task automatic report_mismatch(string what, bit [31:0] got, bit [31:0] want);
        $display("mismatch %s: got %08h expected %08h at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    task automatic write_format(bit fs);
        @(negedge i_clk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = REG_FORMAT;
        pwdata = 32'(fs);
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        fmt_single = fs;
    endtask

    task automatic send_op(logic [1:0] op, bit [31:0] a, bit [31:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_in_valid = 1'b1; i_kind = op; i_operand_a = a; i_operand_b = b;
        do @(posedge i_clk); while (!o_in_ready);
        expected_results.push_back(arith_rtz(fmt_single, op, a, b));
    endtask

    // Let the last transaction go, wait for every result, then let the block settle.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", o_result_bits, 32'd0);
            end else begin
                if (o_result_bits !== expected_results[0])
                    report_mismatch("result_bits", o_result_bits, expected_results[0]);
                void'(expected_results.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("ieee_float_arith_rtz_tb: errors");
            $finish;
        end
    end

    // ---------------- operand generation ----------------
    function automatic bit [31:0] compose(bit fs, bit s, int unsigned e, int unsigned f);
        int mb = mant_bits(fs);
        return zero_bits(fs, s) | (32'(e) << mb) | (32'(f) & ((32'd1 << mb) - 1));
    endfunction

    function automatic bit [31:0] random_operand(bit fs);
        int unsigned emax = fs ? 255 : 31;
        bit          s = $urandom_range(1);
        bit [31:0]   v;
        case ($urandom_range(9))
            0: v = compose(fs, s, 0, 0);
            1: v = compose(fs, s, emax, 0);
            2: v = compose(fs, s, emax, $urandom_range(1) ? $urandom : 1);
            3: v = compose(fs, s, 0, $urandom);
            4: v = compose(fs, s, emax - 1, $urandom);
            5: v = compose(fs, s, 1, $urandom);
            6: v = $urandom;
            default: v = compose(fs, s, $urandom_range(1, emax - 1), $urandom);
        endcase
        if (!fs) v[31:16] = 16'($urandom);
        return v;
    endfunction

    // Operand close in magnitude to ref_val, so cancellation gets exercised.
    function automatic bit [31:0] nearby_operand(bit fs, bit [31:0] ref_val);
        int          mb = mant_bits(fs);
        int unsigned emax = fs ? 255 : 31;
        int          e = int'((ref_val >> mb) & (emax)) + $urandom_range(4) - 2;
        bit [31:0]   f = (ref_val & ((32'd1 << mb) - 1)) ^ ($urandom_range(1) ?
                         32'($urandom_range(7)) : 32'($urandom));
        if (e < 0) e = 0;
        if (e > int'(emax) - 1) e = emax - 1;
        return compose(fs, $urandom_range(1), e, f);
    endfunction

    // ---------------- tests ----------------
    task automatic test_directed(bit fs);
        bit [31:0] pinf = inf_bits(fs);
        bit [31:0] ninf = pinf | zero_bits(fs, 1'b1);
        bit [31:0] fmax = pinf - 1;
        bit [31:0] nzero = zero_bits(fs, 1'b1);
        bit [31:0] one = compose(fs, 0, fs ? 127 : 15, 0);
        bit [31:0] half = compose(fs, 0, fs ? 126 : 14, 0);
        bit [31:0] tiny = 32'd1;
        bit [31:0] snan = pinf | 32'd1;
        write_format(fs);
        send_op(KIND_MUL, fmax, fmax);            // overflow saturates
        send_op(KIND_ADD, fmax, fmax | nzero);
        send_op(KIND_DIV, one, 32'd0);            // divide by zero
        send_op(KIND_DIV, nzero, 32'd0);          // 0/0
        send_op(KIND_SUB, pinf, pinf);            // inf - inf
        send_op(KIND_MUL, 32'd0, ninf);           // 0 * inf
        send_op(KIND_DIV, ninf, pinf);            // inf / inf
        send_op(KIND_DIV, one, ninf);             // finite / inf
        send_op(KIND_ADD, snan, one);
        send_op(KIND_MUL, tiny, half);            // underflow to zero
        send_op(KIND_SUB, one, one);              // exact cancel gives +0
        send_op(KIND_ADD, nzero, nzero);
        send_op(KIND_ADD, tiny, fmax & ~pinf);    // subnormal operands sum to the smallest normal
        send_op(KIND_DIV, tiny, fmax);
        send_op(KIND_SUB, one, tiny);
        drain();
    endtask

    task automatic random_phase(int idle, int stall, bit fs, int count);
        bit [31:0] a;
        bit [31:0] b;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        write_format(fs);
        repeat (count) begin
            a = random_operand(fs);
            b = ($urandom_range(2) == 0) ? nearby_operand(fs, a) : random_operand(fs);
            if (!fs) b[31:16] = 16'($urandom);
            send_op(2'($urandom_range(3)), a, b);
            if ($urandom_range(29) == 0) begin
                // stretch of back-to-back traffic
                send_idle_pct = 0;
                repeat (10) send_op(2'($urandom_range(3)), random_operand(fs),
                                    random_operand(fs));
                send_idle_pct = idle;
            end
        end
        drain();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 400;
        repeat (20) send_op(2'($urandom_range(3)), random_operand(fmt_single),
                            random_operand(fmt_single));
        drain();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed(1'b0);
        test_directed(1'b1);
        random_phase(0, 0, 1'b0, 200);
        random_phase(56, 0, 1'b1, 200);
        random_phase(0, 56, 1'b0, 200);
        random_phase(35, 35, 1'b1, 200);
        test_backpressure();
        random_phase(10, 10, 1'b0, 100);
        if (expected_results.size() != 0)
            report_mismatch("results never arrived", 32'(expected_results.size()), 32'd0);
        if (error_count == 0) begin
            $display("ieee_float_arith_rtz_tb: clean");
        end else begin
            $display("ieee_float_arith_rtz_tb: errors");
        end
        $finish;
    end
endmodule

### ieee_float_arith_rtz.f
+incdir+hw/rtl
hw/rtl/ifa_pkg.sv
hw/rtl/ifa_ctrl.sv
hw/rtl/ifa_dpath.sv
hw/rtl/ieee_float_arith_rtz.sv
hw/rtl/ifa_checker.sv
dv/ieee_float_arith_rtz_tb.sv
